// File: sv/chip8_instruction_executor_assert.svh
// assertion macros used by the chip8 executor controller
`ifndef CHIP8_INSTRUCTION_EXECUTOR_ASSERT_SVH
`define CHIP8_INSTRUCTION_EXECUTOR_ASSERT_SVH

// same-cycle implication, clocked on aclk, off during reset
`define C8IE_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off during reset
`define C8IE_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/c8ie_pkg.sv
// types, opcode codes and font table for the chip8 executor
package c8ie_pkg;

    localparam int MEM_BYTES  = 4096;
    localparam int SCREEN_W   = 64;
    localparam int SCREEN_H   = 32;
    localparam int FONT_BYTES = 80;

    localparam logic [11:0] PC_START  = 12'h200;
    localparam logic [11:0] FONT_BASE = 12'h050;
    localparam logic [11:0] FONT_END  = 12'h0A0;
    localparam logic [11:0] INIT_LAST = 12'hFFF;
    localparam logic [3:0]  REG_VF    = 4'hF;

    localparam logic [7:0] FONT_ROM [FONT_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    // opcode classes (top nibble)
    localparam logic [3:0] OP_SYS   = 4'h0;
    localparam logic [3:0] OP_JP    = 4'h1;
    localparam logic [3:0] OP_CALL  = 4'h2;
    localparam logic [3:0] OP_SE    = 4'h3;
    localparam logic [3:0] OP_SNE   = 4'h4;
    localparam logic [3:0] OP_SEXY  = 4'h5;
    localparam logic [3:0] OP_LD    = 4'h6;
    localparam logic [3:0] OP_ADD   = 4'h7;
    localparam logic [3:0] OP_ALU   = 4'h8;
    localparam logic [3:0] OP_SNEXY = 4'h9;
    localparam logic [3:0] OP_LDI   = 4'hA;
    localparam logic [3:0] OP_RND   = 4'hC;
    localparam logic [3:0] OP_DRW   = 4'hD;
    localparam logic [3:0] OP_MISC  = 4'hF;

    localparam logic [15:0] OP_CLS = 16'h00E0;

    localparam logic [3:0] ALU_MOV  = 4'h0;
    localparam logic [3:0] ALU_OR   = 4'h1;
    localparam logic [3:0] ALU_AND  = 4'h2;
    localparam logic [3:0] ALU_XOR  = 4'h3;
    localparam logic [3:0] ALU_ADD  = 4'h4;
    localparam logic [3:0] ALU_SUB  = 4'h5;
    localparam logic [3:0] ALU_SHR  = 4'h6;
    localparam logic [3:0] ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL  = 4'hE;

    localparam logic [7:0] MISC_GET_DT = 8'h07;
    localparam logic [7:0] MISC_SET_DT = 8'h15;
    localparam logic [7:0] MISC_ADD_I  = 8'h1E;
    localparam logic [7:0] MISC_FONT   = 8'h29;

    typedef enum logic [1:0] {REQ_WRITE, REQ_READ, REQ_PIXEL, REQ_EXEC} req_t;
    typedef enum logic [1:0] {ST_OK, ST_UNKNOWN, ST_STACK_FULL} status_t;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_REQ, S_MEMRD, S_FETCH_LO, S_OPLO, S_RDVX, S_RDVY,
        S_EXEC, S_FLAG, S_DRAW_RD, S_DRAW_WR, S_FIN, S_DONE
    } state_t;

    typedef enum logic [2:0] {ADDR_REQ, ADDR_PC, ADDR_PC1, ADDR_SPR, ADDR_INIT} addr_sel_t;
    typedef enum logic [1:0] {PC_HOLD, PC_NEXT, PC_SKIP, PC_JUMP} pc_ld_t;
    typedef enum logic [1:0] {I_HOLD, I_NNN, I_ADD, I_FONT} i_ld_t;
    typedef enum logic [2:0] {GR_NN, GR_ADD_NN, GR_ALU, GR_RND, GR_DELAY, GR_FLAG} gr_src_t;

    typedef struct packed {
        logic      cap_req;
        logic      mem_we;
        addr_sel_t addr_sel;
        logic      init_step;
        logic      cap_hi;
        logic      cap_lo;
        logic      cap_vx;
        logic      cap_vy;
        logic      gr_we;
        logic      gr_to_vf;
        gr_src_t   gr_src;
        pc_ld_t    pc_ld;
        i_ld_t     i_ld;
        logic      delay_ld;
        logic      delay_dec;
        logic      push;
        logic      frame_clr;
        logic      row_clr;
        logic      draw_row;
        logic      cap_mem;
        logic      cap_pix;
        logic      out_load;
        status_t   out_status;
    } c8ie_cmd_t;

    typedef struct packed {
        logic        init_done;
        req_t        req_type;
        logic [15:0] op;
        logic        vx_eq_nn;
        logic        vx_eq_vy;
        logic        stack_full;
        logic        rows_done;
    } c8ie_stat_t;

    // power-up content of main memory: font digits, rest zero
    function automatic logic [7:0] font_byte(input logic [11:0] a);
        logic [11:0] off;
        begin
            off = a - FONT_BASE;
            if (a >= FONT_BASE && a < FONT_END) begin
                font_byte = FONT_ROM[off[6:0]];
            end else begin
                font_byte = 8'h00;
            end
        end
    endfunction

endpackage

// File: sv/c8ie_datapath.sv
// datapath: main memory, registers, stack, frame buffer and alu
module c8ie_datapath import c8ie_pkg::*; #(
    parameter int STACK_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [1:0]  s_req_type,
    input  logic [11:0] s_address,
    input  logic [7:0]  s_write_data,
    input  logic [7:0]  s_random_byte,
    input  c8ie_cmd_t   cmd,
    output c8ie_stat_t  stat,
    output logic [1:0]  m_status,
    output logic [11:0] m_program_counter,
    output logic [7:0]  m_read_data
);

    localparam int SP_W  = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    logic [7:0]  main_mem [MEM_BYTES];
    logic [11:0] stack_mem [STACK_DEPTH];

    req_t        req_type_reg;
    logic [11:0] addr_reg;
    logic [7:0]  wdata_reg;
    logic [7:0]  rnd_reg;
    logic [15:0] op_reg;
    logic [7:0]  vx_reg;
    logic [7:0]  vy_reg;
    logic [7:0]  rdata_reg;
    logic [7:0]  dat_reg;
    logic [1:0]  m_status_reg;
    logic [11:0] m_pc_reg;
    logic [7:0]  m_data_reg;

    logic [11:0] pc_reg;
    logic [11:0] i_reg;
    logic [SP_W-1:0] sp_reg;
    logic [7:0]  delay_reg;
    logic [3:0]  row_reg;
    logic [11:0] init_cnt_reg;
    logic        init_done_reg;
    logic [7:0]  gr_reg [16];
    logic [SCREEN_W-1:0] frame_reg [SCREEN_H];

    logic [11:0] mem_addr;
    logic [7:0]  mem_wdata;
    logic [11:0] pc_next2;
    logic [3:0]  gr_raddr;
    logic [3:0]  gr_waddr;
    logic [7:0]  gr_wdata;
    logic [7:0]  alu_res;
    logic        alu_flag;
    logic [8:0]  alu_sum;
    logic [7:0]  nn;
    logic [4:0]  draw_y;
    logic [4:0]  frame_raddr;
    logic [SCREEN_W-1:0] frame_rrow;
    logic [SCREEN_W-1:0] spr_pat;
    logic [SCREEN_W-1:0] spr_rot;
    logic [7:0]  spr_rev;
    logic [6:0]  rot_back;
    logic [7:0]  pix_data;

    assign nn       = op_reg[7:0];
    assign pc_next2 = pc_reg + 12'd2;

    always_comb begin
        case (cmd.addr_sel)
            ADDR_REQ:  mem_addr = addr_reg;
            ADDR_PC:   mem_addr = pc_reg;
            ADDR_PC1:  mem_addr = pc_reg + 12'd1;
            ADDR_SPR:  mem_addr = i_reg + {8'd0, row_reg};
            ADDR_INIT: mem_addr = init_cnt_reg;
            default:   mem_addr = 12'd0;
        endcase
    end

    assign mem_wdata = cmd.init_step ? font_byte(init_cnt_reg) : wdata_reg;

    always_ff @(posedge aclk) begin
        if (cmd.mem_we) begin
            main_mem[mem_addr] <= mem_wdata;
        end
        rdata_reg <= main_mem[mem_addr];
    end

    // single read port on the register file, vy read in the cycle after vx
    assign gr_raddr = cmd.cap_vy ? op_reg[7:4] : op_reg[11:8];
    assign gr_waddr = cmd.gr_to_vf ? REG_VF : op_reg[11:8];

    always_comb begin
        alu_sum  = {1'b0, vx_reg} + {1'b0, vy_reg};
        alu_res  = vy_reg;
        alu_flag = 1'b0;
        case (op_reg[3:0])
            ALU_MOV:  alu_res = vy_reg;
            ALU_OR:   alu_res = vx_reg | vy_reg;
            ALU_AND:  alu_res = vx_reg & vy_reg;
            ALU_XOR:  alu_res = vx_reg ^ vy_reg;
            ALU_ADD: begin
                alu_res  = alu_sum[7:0];
                alu_flag = alu_sum[8];
            end
            ALU_SUB: begin
                alu_res  = vx_reg - vy_reg;
                alu_flag = (vx_reg >= vy_reg);
            end
            ALU_SHR: begin
                alu_res  = {1'b0, vy_reg[7:1]};
                alu_flag = vy_reg[0];
            end
            ALU_SUBN: begin
                alu_res  = vy_reg - vx_reg;
                alu_flag = (vy_reg >= vx_reg);
            end
            ALU_SHL: begin
                alu_res  = {vy_reg[6:0], 1'b0};
                alu_flag = vy_reg[7];
            end
            default: begin
                alu_res  = vy_reg;
                alu_flag = 1'b0;
            end
        endcase
    end

    always_comb begin
        case (cmd.gr_src)
            GR_NN:     gr_wdata = nn;
            GR_ADD_NN: gr_wdata = vx_reg + nn;
            GR_ALU:    gr_wdata = alu_res;
            GR_RND:    gr_wdata = rnd_reg & nn;
            GR_DELAY:  gr_wdata = delay_reg;
            GR_FLAG:   gr_wdata = {7'd0, alu_flag};
            default:   gr_wdata = 8'd0;
        endcase
    end

    // sprite row: bit 7 is leftmost, placed at vx and wrapped around the row
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            spr_rev[k] = rdata_reg[7-k];
        end
    end
    assign spr_pat  = {{(SCREEN_W-8){1'b0}}, spr_rev};
    assign rot_back = 7'd64 - {1'b0, vx_reg[5:0]};
    assign spr_rot  = (spr_pat << vx_reg[5:0]) | (spr_pat >> rot_back);

    assign draw_y      = vy_reg[4:0] + {1'b0, row_reg};
    assign frame_raddr = cmd.cap_pix ? addr_reg[10:6] : draw_y;
    assign frame_rrow  = frame_reg[frame_raddr];
    assign pix_data    = addr_reg[11] ? 8'd0 : {7'd0, frame_rrow[addr_reg[5:0]]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg        <= PC_START;
            i_reg         <= 12'd0;
            sp_reg        <= '0;
            delay_reg     <= 8'd0;
            row_reg       <= 4'd0;
            init_cnt_reg  <= 12'd0;
            init_done_reg <= 1'b0;
            for (int r = 0; r < 16; r++) begin
                gr_reg[r] <= 8'd0;
            end
            for (int r = 0; r < SCREEN_H; r++) begin
                frame_reg[r] <= '0;
            end
        end else begin
            if (cmd.init_step) begin
                init_cnt_reg <= init_cnt_reg + 12'd1;
                if (init_cnt_reg == INIT_LAST) begin
                    init_done_reg <= 1'b1;
                end
            end
            case (cmd.pc_ld)
                PC_NEXT: pc_reg <= pc_next2;
                PC_SKIP: pc_reg <= pc_reg + 12'd4;
                PC_JUMP: pc_reg <= op_reg[11:0];
                default: pc_reg <= pc_reg;
            endcase
            case (cmd.i_ld)
                I_NNN:   i_reg <= op_reg[11:0];
                I_ADD:   i_reg <= i_reg + {4'd0, vx_reg};
                I_FONT:  i_reg <= FONT_BASE + {2'd0, vx_reg, 2'd0} + {4'd0, vx_reg};
                default: i_reg <= i_reg;
            endcase
            if (cmd.push) begin
                sp_reg <= sp_reg + 1'b1;
            end
            if (cmd.delay_ld) begin
                delay_reg <= vx_reg;
            end else if (cmd.delay_dec && delay_reg != 8'd0) begin
                delay_reg <= delay_reg - 8'd1;
            end
            if (cmd.row_clr) begin
                row_reg <= 4'd0;
            end else if (cmd.draw_row) begin
                row_reg <= row_reg + 4'd1;
            end
            if (cmd.gr_we) begin
                gr_reg[gr_waddr] <= gr_wdata;
            end
            if (cmd.frame_clr) begin
                for (int r = 0; r < SCREEN_H; r++) begin
                    frame_reg[r] <= '0;
                end
            end else if (cmd.draw_row) begin
                frame_reg[draw_y] <= frame_rrow ^ spr_rot;
            end
        end
    end

    // return addresses, pushed by call (pc + 2)
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            stack_mem[sp_reg[IDX_W-1:0]] <= pc_next2;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cap_req) begin
            req_type_reg <= req_t'(s_req_type);
            addr_reg     <= s_address;
            wdata_reg    <= s_write_data;
            rnd_reg      <= s_random_byte;
            dat_reg      <= 8'd0;
        end else if (cmd.cap_mem) begin
            dat_reg <= rdata_reg;
        end else if (cmd.cap_pix) begin
            dat_reg <= pix_data;
        end
        if (cmd.cap_hi) begin
            op_reg[15:8] <= rdata_reg;
        end
        if (cmd.cap_lo) begin
            op_reg[7:0] <= rdata_reg;
        end
        if (cmd.cap_vx) begin
            vx_reg <= gr_reg[gr_raddr];
        end
        if (cmd.cap_vy) begin
            vy_reg <= gr_reg[gr_raddr];
        end
        if (cmd.out_load) begin
            m_status_reg <= cmd.out_status;
            m_pc_reg     <= pc_reg;
            m_data_reg   <= dat_reg;
        end
    end

    assign stat.init_done  = init_done_reg;
    assign stat.req_type   = req_type_reg;
    assign stat.op         = op_reg;
    assign stat.vx_eq_nn   = (vx_reg == nn);
    assign stat.vx_eq_vy   = (vx_reg == vy_reg);
    assign stat.stack_full = (sp_reg >= SP_W'(STACK_DEPTH));
    assign stat.rows_done  = (row_reg == op_reg[3:0]);

    assign m_status          = m_status_reg;
    assign m_program_counter = m_pc_reg;
    assign m_read_data       = m_data_reg;

endmodule

// File: sv/c8ie_ctrl.sv
// controller: request sequencing, opcode decode and result handshake
`include "chip8_instruction_executor_assert.svh"

module c8ie_ctrl import c8ie_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  c8ie_stat_t stat,
    output c8ie_cmd_t  cmd
);

    state_t  state_reg, state_next;
    status_t st_reg, st_next;
    logic    m_valid_reg, m_valid_next;
    status_t dec_err;
    state_t  dec_tail;
    logic    slot_free;

    assign slot_free = !m_valid_reg || m_ready;

    // opcode decode: error code and the state after execute
    always_comb begin
        dec_err = ST_OK;
        unique case (stat.op[15:12])
            OP_SYS: begin
                if (stat.op != OP_CLS) begin
                    dec_err = ST_UNKNOWN;
                end
            end
            OP_CALL: begin
                if (stat.stack_full) begin
                    dec_err = ST_STACK_FULL;
                end
            end
            OP_ALU: begin
                unique case (stat.op[3:0]) inside
                    ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB, ALU_SHR,
                    ALU_SUBN, ALU_SHL: dec_err = ST_OK;
                    default: dec_err = ST_UNKNOWN;
                endcase
            end
            OP_MISC: begin
                unique case (stat.op[7:0]) inside
                    MISC_GET_DT, MISC_SET_DT, MISC_ADD_I, MISC_FONT: dec_err = ST_OK;
                    default: dec_err = ST_UNKNOWN;
                endcase
            end
            OP_JP, OP_SE, OP_SNE, OP_SEXY, OP_LD, OP_ADD, OP_SNEXY, OP_LDI, OP_RND,
            OP_DRW: dec_err = ST_OK;
            default: dec_err = ST_UNKNOWN;
        endcase
    end

    always_comb begin
        if (dec_err != ST_OK) begin
            dec_tail = S_DONE;
        end else if (stat.op[15:12] == OP_DRW) begin
            dec_tail = S_DRAW_RD;
        end else if (stat.op[15:12] == OP_ALU && stat.op[3:0] != ALU_MOV
                     && stat.op[3:0] != ALU_OR && stat.op[3:0] != ALU_AND
                     && stat.op[3:0] != ALU_XOR) begin
            dec_tail = S_FLAG;
        end else begin
            dec_tail = S_FIN;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:     if (stat.init_done) state_next = S_IDLE;
            S_IDLE:     if (s_valid) state_next = S_REQ;
            S_REQ: begin
                unique case (stat.req_type)
                    REQ_READ: state_next = S_MEMRD;
                    REQ_EXEC: state_next = S_FETCH_LO;
                    default:  state_next = S_DONE;
                endcase
            end
            S_MEMRD:    state_next = S_DONE;
            S_FETCH_LO: state_next = S_OPLO;
            S_OPLO:     state_next = S_RDVX;
            S_RDVX:     state_next = S_RDVY;
            S_RDVY:     state_next = S_EXEC;
            S_EXEC:     state_next = dec_tail;
            S_FLAG:     state_next = S_FIN;
            S_DRAW_RD:  state_next = stat.rows_done ? S_FIN : S_DRAW_WR;
            S_DRAW_WR:  state_next = S_DRAW_RD;
            S_FIN:      state_next = S_DONE;
            S_DONE:     if (slot_free) state_next = S_IDLE;
            default:    state_next = S_INIT;
        endcase
    end

    // outputs
    always_comb begin
        cmd            = '0;
        cmd.out_status = st_reg;
        s_ready        = 1'b0;
        st_next        = st_reg;
        unique case (state_reg)
            S_INIT: begin
                cmd.init_step = !stat.init_done;
                cmd.mem_we    = !stat.init_done;
                cmd.addr_sel  = ADDR_INIT;
            end
            S_IDLE: begin
                s_ready     = 1'b1;
                cmd.cap_req = s_valid;
                if (s_valid) begin
                    st_next = ST_OK;
                end
            end
            S_REQ: begin
                unique case (stat.req_type)
                    REQ_WRITE: begin
                        cmd.mem_we   = 1'b1;
                        cmd.addr_sel = ADDR_REQ;
                    end
                    REQ_READ:  cmd.addr_sel = ADDR_REQ;
                    REQ_PIXEL: cmd.cap_pix  = 1'b1;
                    default:   cmd.addr_sel = ADDR_PC;
                endcase
            end
            S_MEMRD: cmd.cap_mem = 1'b1;
            S_FETCH_LO: begin
                cmd.cap_hi   = 1'b1;
                cmd.addr_sel = ADDR_PC1;
            end
            S_OPLO: cmd.cap_lo = 1'b1;
            S_RDVX: cmd.cap_vx = 1'b1;
            S_RDVY: cmd.cap_vy = 1'b1;
            S_EXEC: begin
                st_next = dec_err;
                if (dec_err == ST_OK) begin
                    cmd.pc_ld = PC_NEXT;
                    unique case (stat.op[15:12])
                        OP_SYS:   cmd.frame_clr = 1'b1;
                        OP_JP:    cmd.pc_ld = PC_JUMP;
                        OP_CALL: begin
                            cmd.push  = 1'b1;
                            cmd.pc_ld = PC_JUMP;
                        end
                        OP_SE:    cmd.pc_ld = stat.vx_eq_nn ? PC_SKIP : PC_NEXT;
                        OP_SNE:   cmd.pc_ld = stat.vx_eq_nn ? PC_NEXT : PC_SKIP;
                        OP_SEXY:  cmd.pc_ld = stat.vx_eq_vy ? PC_SKIP : PC_NEXT;
                        OP_SNEXY: cmd.pc_ld = stat.vx_eq_vy ? PC_NEXT : PC_SKIP;
                        OP_LD: begin
                            cmd.gr_we  = 1'b1;
                            cmd.gr_src = GR_NN;
                        end
                        OP_ADD: begin
                            cmd.gr_we  = 1'b1;
                            cmd.gr_src = GR_ADD_NN;
                        end
                        OP_ALU: begin
                            cmd.gr_we  = 1'b1;
                            cmd.gr_src = GR_ALU;
                        end
                        OP_LDI:   cmd.i_ld = I_NNN;
                        OP_RND: begin
                            cmd.gr_we  = 1'b1;
                            cmd.gr_src = GR_RND;
                        end
                        OP_DRW:   cmd.row_clr = 1'b1;
                        OP_MISC: begin
                            unique case (stat.op[7:0])
                                MISC_GET_DT: begin
                                    cmd.gr_we  = 1'b1;
                                    cmd.gr_src = GR_DELAY;
                                end
                                MISC_SET_DT: cmd.delay_ld = 1'b1;
                                MISC_ADD_I:  cmd.i_ld = I_ADD;
                                default:     cmd.i_ld = I_FONT;
                            endcase
                        end
                        default: cmd.pc_ld = PC_HOLD;
                    endcase
                end
            end
            S_FLAG: begin
                cmd.gr_we    = 1'b1;
                cmd.gr_to_vf = 1'b1;
                cmd.gr_src   = GR_FLAG;
            end
            S_DRAW_RD: cmd.addr_sel  = ADDR_SPR;
            S_DRAW_WR: cmd.draw_row  = 1'b1;
            S_FIN:     cmd.delay_dec = 1'b1;
            S_DONE:    cmd.out_load  = slot_free;
            default:   cmd.out_load  = 1'b0;
        endcase
    end

    assign m_valid_next = cmd.out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            st_reg      <= ST_OK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            st_reg      <= st_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    `C8IE_ASSERT_SAME(a_ready_after_init, s_ready, stat.init_done, "transaction taken before memory init")
    `C8IE_ASSERT_SAME(a_load_slot_free, cmd.out_load, (!m_valid_reg || m_ready), "result overwrites pending transaction")
    `C8IE_ASSERT_NEXT(a_one_in_flight, (s_valid && s_ready), !s_ready, "second transaction taken while busy")
    `C8IE_ASSERT_SAME(a_err_no_update, (state_reg == S_EXEC && dec_err != ST_OK), (cmd.pc_ld == PC_HOLD && !cmd.frame_clr && !cmd.gr_we && !cmd.push), "failed execute changes state")

endmodule

// File: sv/chip8_instruction_executor.sv
// chip8 instruction executor top level
//
//  channel | ports                                              | direction
//  --------+----------------------------------------------------+----------
//  request | s_valid s_ready s_req_type s_address s_write_data  | in
//          | s_random_byte                                      |
//  result  | m_valid m_ready m_status m_program_counter         | out
//          | m_read_data                                        |
//
// one transaction in flight; the result register frees the request side
// memory write and pixel read step through REQ and DONE; memory read adds MEMRD
// execute: REQ, FETCH_LO, OPLO, RDVX, RDVY, EXEC, FIN, DONE; flag write adds FLAG
// unknown opcode or full stack skips FIN; draw: DRAW_RD, DRAW_WR per sprite row
// one main memory port; after reset it is loaded with font and zeros, s_ready low
// a stalled result holds the block in its last step until m_ready
module chip8_instruction_executor import c8ie_pkg::*; #(
    parameter int STACK_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [11:0] s_address,
    input  logic [7:0]  s_write_data,
    input  logic [7:0]  s_random_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [11:0] m_program_counter,
    output logic [7:0]  m_read_data
);

    c8ie_cmd_t  cmd;
    c8ie_stat_t stat;

    c8ie_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    c8ie_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_req_type        (s_req_type),
        .s_address         (s_address),
        .s_write_data      (s_write_data),
        .s_random_byte     (s_random_byte),
        .cmd               (cmd),
        .stat              (stat),
        .m_status          (m_status),
        .m_program_counter (m_program_counter),
        .m_read_data       (m_read_data)
    );

endmodule
